// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the checker file of this block.
// Each macro expands to one labelled concurrent assertion that is sampled on
// the rising edge of the given clock and switched off while the given
// active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_IMPLIES_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tftpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tftpc_pkg
// Types, codes and helper functions of the lock-step TFTP client controller.
// ----------------------------------------------------------------------------
package tftpc_pkg;

    localparam int ACTION_W   = 3;
    localparam int BLOCK_W    = 16;
    localparam int LEN_W      = 10;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int TOTAL_W    = 32;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Event codes.
    localparam logic [ACTION_W-1:0] ACT_START     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PACKET    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TIMEOUT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SRV_ERR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_OTHER_ERR = 3'd4;

    // Packet kinds to send.
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RRQ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRQ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DATA = 3'd4;

    // Reported status.
    localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FAIL_TMO = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FAIL_ERR = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd1;
    localparam logic [TMO_W-1:0]     TIMEOUT_LIMIT_RST = 16'd10;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_REQ  = 3'd1,
        PH_XFER = 3'd2,
        PH_DONE = 3'd3,
        PH_FTMO = 3'd4,
        PH_FERR = 3'd5
    } phase_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BLOCK_W-1:0]  rx_block;
        logic [LEN_W-1:0]    rx_data_len;
        logic [LEN_W-1:0]    next_chunk_len;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   send_kind;
        logic [BLOCK_W-1:0]  send_block;
        logic [LEN_W-1:0]    send_len;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  byte_total;
    } result_t;

    function automatic logic [STATUS_W-1:0] status_of(phase_t ph);
        logic [STATUS_W-1:0] st;
        case (ph)
            PH_REQ, PH_XFER: st = STAT_BUSY;
            PH_DONE:         st = STAT_DONE;
            PH_FTMO:         st = STAT_FAIL_TMO;
            PH_FERR:         st = STAT_FAIL_ERR;
            default:         st = STAT_IDLE;
        endcase
        return st;
    endfunction

endpackage

// ===== rtl/tftpc_in_reg.sv =====
// ----------------------------------------------------------------------------
// tftpc_in_reg
// Input register: holds one event until the engine consumes it.
// ----------------------------------------------------------------------------
module tftpc_in_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tftpc_pkg::item_t s_item,
    input  logic             take,
    output logic             item_valid,
    output tftpc_pkg::item_t item
);
    import tftpc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/tftpc_engine.sv =====
// ----------------------------------------------------------------------------
// tftpc_engine
// Transfer state and configuration registers with the per-event update logic.
// ----------------------------------------------------------------------------
module tftpc_engine #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tftpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tftpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                fire,
    input  tftpc_pkg::item_t                    item,
    output tftpc_pkg::result_t                  result
);
    import tftpc_pkg::*;

    // Lengths are compared on 17 bits so that any block size in range works.
    localparam int              CMP_W       = 17;
    localparam logic [CMP_W-1:0] BLOCK_LIMIT = CMP_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] LEN_CAP     = LEN_W'(BLOCK_BYTES);

    logic               direction_reg;
    logic [TMO_W-1:0]   timeout_limit_reg;

    phase_t             phase_reg,  phase_next;
    logic [BLOCK_W-1:0] exp_block_reg, exp_block_next;
    logic [TMO_W-1:0]   tmo_count_reg, tmo_count_next;
    logic [LEN_W-1:0]   last_len_reg, last_len_next;
    logic [TOTAL_W-1:0] bytes_reg, bytes_next;

    logic               busy;
    logic               put;
    logic [LEN_W-1:0]   rx_len_clamped;
    logic [LEN_W-1:0]   tx_len_clamped;
    logic [LEN_W-1:0]   addend;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] bytes_sat;
    logic [TMO_W-1:0]   tmo_inc;
    logic [BLOCK_W-1:0] exp_block_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg     <= 1'b0;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DIRECTION:     direction_reg     <= cfg_wdata[0];
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            exp_block_reg <= '0;
            tmo_count_reg <= '0;
            last_len_reg  <= '0;
            bytes_reg     <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            exp_block_reg <= exp_block_next;
            tmo_count_reg <= tmo_count_next;
            last_len_reg  <= last_len_next;
            bytes_reg     <= bytes_next;
        end
    end

    assign busy = (phase_reg == PH_REQ) || (phase_reg == PH_XFER);
    assign put  = direction_reg;

    assign rx_len_clamped = (CMP_W'(item.rx_data_len) > BLOCK_LIMIT) ? LEN_CAP
                                                                     : item.rx_data_len;
    assign tx_len_clamped = (CMP_W'(item.next_chunk_len) > BLOCK_LIMIT) ? LEN_CAP
                                                                        : item.next_chunk_len;

    // Saturating byte total: in put mode the acknowledged block is counted.
    assign addend    = put ? last_len_reg : rx_len_clamped;
    assign sum       = {1'b0, bytes_reg} + (TOTAL_W+1)'(addend);
    assign bytes_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

    assign tmo_inc       = (tmo_count_reg == '1) ? tmo_count_reg : tmo_count_reg + 1'b1;
    assign exp_block_inc = exp_block_reg + 1'b1;

    always_comb begin
        phase_next        = phase_reg;
        exp_block_next    = exp_block_reg;
        tmo_count_next    = tmo_count_reg;
        last_len_next     = last_len_reg;
        bytes_next        = bytes_reg;
        result.send_kind  = KIND_NONE;
        result.send_block = '0;
        result.send_len   = '0;
        case (item.action)
            ACT_START: begin
                exp_block_next   = put ? '0 : BLOCK_W'(1);
                tmo_count_next   = '0;
                last_len_next    = '0;
                bytes_next       = '0;
                phase_next       = PH_REQ;
                result.send_kind = put ? KIND_WRQ : KIND_RRQ;
            end
            ACT_PACKET: begin
                if (busy) begin
                    tmo_count_next = '0;
                    if (item.rx_block == exp_block_reg) begin
                        bytes_next = bytes_sat;
                        if (!put) begin
                            last_len_next     = rx_len_clamped;
                            result.send_kind  = KIND_ACK;
                            result.send_block = exp_block_reg;
                            exp_block_next    = exp_block_inc;
                            phase_next = (CMP_W'(rx_len_clamped) < BLOCK_LIMIT) ? PH_DONE
                                                                                 : PH_XFER;
                        end else if (phase_reg == PH_XFER &&
                                     CMP_W'(last_len_reg) < BLOCK_LIMIT) begin
                            phase_next = PH_DONE;
                        end else begin
                            last_len_next     = tx_len_clamped;
                            exp_block_next    = exp_block_inc;
                            phase_next        = PH_XFER;
                            result.send_kind  = KIND_DATA;
                            result.send_block = exp_block_inc;
                            result.send_len   = tx_len_clamped;
                        end
                    end
                end
            end
            ACT_TIMEOUT: begin
                if (busy) begin
                    tmo_count_next = tmo_inc;
                    if (tmo_inc >= timeout_limit_reg) begin
                        phase_next = PH_FTMO;
                    end else if (phase_reg == PH_REQ) begin
                        result.send_kind = put ? KIND_WRQ : KIND_RRQ;
                    end else if (!put) begin
                        result.send_kind  = KIND_ACK;
                        result.send_block = exp_block_reg - 1'b1;
                    end else begin
                        result.send_kind  = KIND_DATA;
                        result.send_block = exp_block_reg;
                        result.send_len   = last_len_reg;
                    end
                end
            end
            ACT_SRV_ERR, ACT_OTHER_ERR: begin
                if (busy) begin
                    phase_next = PH_FERR;
                end
            end
            default: ;
        endcase
        result.status     = status_of(phase_next);
        result.byte_total = bytes_next;
    end

endmodule

// ===== rtl/tftpc_out_reg.sv =====
// ----------------------------------------------------------------------------
// tftpc_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tftpc_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_valid,
    output logic               can_load,
    input  tftpc_pkg::result_t load_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tftpc_pkg::result_t m_data
);
    import tftpc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = (load_valid && can_load) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && can_load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/tftp_client_transfer_control_core.sv =====
// ----------------------------------------------------------------------------
// tftp_client_transfer_control_core: lock-step TFTP client transfer control.
// Flow: an event waits in the input register until the result register can
// take its result. Throughput: one event per cycle unless results stall.
// Reset: synchronous, active low; clears state and restores config defaults.
// ----------------------------------------------------------------------------
module tftp_client_transfer_control_core #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [tftpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tftpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Event channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tftpc_pkg::ACTION_W-1:0]      s_action,
    input  logic [tftpc_pkg::BLOCK_W-1:0]       s_rx_block,
    input  logic [tftpc_pkg::LEN_W-1:0]         s_rx_data_len,
    input  logic [tftpc_pkg::LEN_W-1:0]         s_next_chunk_len,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tftpc_pkg::KIND_W-1:0]        m_send_kind,
    output logic [tftpc_pkg::BLOCK_W-1:0]       m_send_block,
    output logic [tftpc_pkg::LEN_W-1:0]         m_send_len,
    output logic [tftpc_pkg::STATUS_W-1:0]      m_status,
    output logic [tftpc_pkg::TOTAL_W-1:0]       m_byte_total
);
    import tftpc_pkg::*;

    // The datapath is a two-register pipeline. The input register captures an
    // event on each transfer of the event channel. The engine evaluates the held
    // event against the transfer state; once the result register can take it,
    // the state is updated on the same clock edge that loads the result register.
    // Because the state is updated in the very cycle the result is produced,
    // the next event can follow directly without any hazard.

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t m_data;

    assign s_item.action         = s_action;
    assign s_item.rx_block       = s_rx_block;
    assign s_item.rx_data_len    = s_rx_data_len;
    assign s_item.next_chunk_len = s_next_chunk_len;

    // An event leaves the input register only when the result register can
    // take its result, so a stalled result channel stalls the whole pipeline
    // but nothing is ever dropped or duplicated.
    assign fire = item_valid && can_load;

    tftpc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    // The engine holds the configuration registers, the expected block
    // number, the timeout counter, the last chunk length, the phase and the
    // saturating byte total. Its transfer state advances only on a fired event.
    tftpc_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    // Every event produces exactly one result, including ignored events,
    // which report nothing to send and the unchanged status.
    tftpc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (item_valid),
        .can_load   (can_load),
        .load_data  (result),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_send_kind  = m_data.send_kind;
    assign m_send_block = m_data.send_block;
    assign m_send_len   = m_data.send_len;
    assign m_status     = m_data.status;
    assign m_byte_total = m_data.byte_total;

endmodule

// ===== rtl/tftpc_checker.sv =====
// ----------------------------------------------------------------------------
// tftpc_checker
// Port-level assertions for the transfer controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tftpc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [tftpc_pkg::KIND_W-1:0]        m_send_kind,
    input logic [tftpc_pkg::BLOCK_W-1:0]       m_send_block,
    input logic [tftpc_pkg::LEN_W-1:0]         m_send_len,
    input logic [tftpc_pkg::STATUS_W-1:0]      m_status,
    input logic [tftpc_pkg::TOTAL_W-1:0]       m_byte_total
);
    import tftpc_pkg::*;

    // A stalled result stays valid and keeps its kind, block, status and byte total.
    `ASSERT_IMPLIES_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_send_kind) && $stable(m_send_block) && $stable(m_status) && $stable(m_byte_total), "stalled result changed")

    // With nothing to send the block and length fields are zero.
    `ASSERT_IMPLIES(a_none_zero, aclk, aresetn, m_valid && m_send_kind == KIND_NONE, m_send_block == '0 && m_send_len == '0, "empty result carries block or length")

    // A request, first or resent, reports busy status while nothing is counted yet.
    `ASSERT_IMPLIES(a_request_busy, aclk, aresetn, m_valid && (m_send_kind == KIND_RRQ || m_send_kind == KIND_WRQ), m_status == STAT_BUSY, "request sent while not busy")

    // Idle is only seen before the first start, so nothing has been counted.
    `ASSERT_IMPLIES(a_idle_quiet, aclk, aresetn, m_valid && m_status == STAT_IDLE, m_byte_total == '0 && m_send_kind == KIND_NONE, "idle result not quiet")

endmodule

bind tftp_client_transfer_control_core tftpc_checker u_tftpc_checker (.*);
